// ===== rtl/chunked_payload_reassembler_core_defines.svh =====
// ----------------------------------------------------------------------------
// chunked payload reassembler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CHUNKED_PAYLOAD_REASSEMBLER_CORE_DEFINES_SVH
`define CHUNKED_PAYLOAD_REASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CPRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cprs check failed: same-cycle rule");

// next-cycle implication, disabled while reset is low
`define CPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cprs check failed: next-cycle rule");

`endif

// ===== rtl/cprs_pkg.sv =====
// ----------------------------------------------------------------------------
// cprs_pkg
// types and constants of the chunked payload reassembler
// ----------------------------------------------------------------------------
`default_nettype none

package cprs_pkg;

    // largest declared payload size (0xff * 4)
    localparam int unsigned MAX_PAYLOAD = 1020;

    localparam int unsigned SIZE_W = 10;

    // command codes
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // size bytes still expected
    localparam logic [1:0] SZ_NONE = 2'd0;
    localparam logic [1:0] SZ_LOW  = 2'd1;
    localparam logic [1:0] SZ_HIGH = 2'd2;

    // one input transaction
    typedef struct packed {
        logic       cmd;
        logic       first_chunk;
        logic [7:0] chunk_len;
        logic [7:0] handler_id;
        logic [7:0] data_byte;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic [1:0]        status;
        logic              byte_valid;
        logic [7:0]        payload_byte;
        logic [SIZE_W-1:0] byte_offset;
        logic              last;
    } t_out_item;

    // session state
    typedef struct packed {
        logic              session_busy;
        logic [SIZE_W-1:0] total_size;
        logic [SIZE_W-1:0] bytes_received;
        logic [7:0]        owner_id;
        logic [7:0]        chunk_left;
        logic [1:0]        size_bytes_pending;
        logic [7:0]        size_high_byte;
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/chunked_payload_reassembler_core.sv =====
// ----------------------------------------------------------------------------
// chunked_payload_reassembler_core
// checks length-prefixed chunks and forwards payload bytes with offsets
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   ------------------------   ----------------------------------
//   input     i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   result    o_out_valid / i_out_ready  o_out_data (t_out_item)
//
// one result per input transaction, shown the cycle after acceptance
// sustained rate is one transaction per cycle while i_out_ready stays high; the result register holds it
// o_in_ready is high whenever the result register is empty or being drained
// a stalled result holds the input side off until it is taken
// synchronous active-low reset clears the session and the result valid
//
`default_nettype none

module chunked_payload_reassembler_core
    import cprs_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_item o_out_data
);

    t_state    r_state;
    t_state    n_state;
    t_out_item r_result;
    t_out_item n_result;
    logic      r_out_valid;
    logic      in_fire;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_result;

    // per-transaction decode
    cprs_step u_step (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // session state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cprs_step.sv =====
// ----------------------------------------------------------------------------
// cprs_step
// next session state and result for one transaction
// ----------------------------------------------------------------------------
`default_nettype none

module cprs_step
    import cprs_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    logic        err;
    logic [15:0] size_word;
    logic [7:0]  left_dec;
    logic [SIZE_W:0]   hdr_sum;
    logic [SIZE_W-1:0] recv_inc;

    assign size_word = {i_state.size_high_byte, i_item.data_byte};
    assign left_dec  = i_state.chunk_left - 8'd1;
    assign hdr_sum   = {1'b0, i_state.bytes_received} + {3'b000, i_item.chunk_len};
    assign recv_inc  = i_state.bytes_received + {{(SIZE_W-1){1'b0}}, 1'b1};

    // decode the transaction against the session
    always_comb begin
        err      = 1'b0;
        o_state  = i_state;
        o_result = '0;
        o_result.status = ST_OK;

        if (i_item.cmd == CMD_DATA) begin
            priority if (i_state.chunk_left == 8'd0) begin
                err = 1'b1;
            end else if (i_state.size_bytes_pending == SZ_HIGH) begin
                o_state.chunk_left         = left_dec;
                o_state.size_high_byte     = i_item.data_byte;
                o_state.size_bytes_pending = SZ_LOW;
            end else if (i_state.size_bytes_pending == SZ_LOW) begin
                o_state.chunk_left         = left_dec;
                o_state.size_bytes_pending = SZ_NONE;
                o_state.size_high_byte     = 8'd0;
                // size checks and first chunk overrun
                if ((size_word == 16'd0) || (size_word > 16'(MAX_PAYLOAD))
                        || ({8'd0, left_dec} > size_word)) begin
                    err = 1'b1;
                end else begin
                    o_state.total_size = size_word[SIZE_W-1:0];
                end
            end else begin
                // forward a payload byte
                o_result.byte_valid   = 1'b1;
                o_result.payload_byte = i_item.data_byte;
                o_result.byte_offset  = i_state.bytes_received;
                if (recv_inc >= i_state.total_size) begin
                    o_state         = '0;
                    o_result.status = ST_DONE;
                    o_result.last   = 1'b1;
                end else begin
                    o_state.chunk_left     = left_dec;
                    o_state.bytes_received = recv_inc;
                end
            end
        end else begin
            priority if (i_state.chunk_left != 8'd0) begin
                err = 1'b1;
            end else if (i_item.first_chunk) begin
                if (i_state.session_busy || (i_item.chunk_len < 8'd2)) begin
                    err = 1'b1;
                end else begin
                    o_state.session_busy       = 1'b1;
                    o_state.owner_id           = i_item.handler_id;
                    o_state.total_size         = '0;
                    o_state.bytes_received     = '0;
                    o_state.chunk_left         = i_item.chunk_len;
                    o_state.size_bytes_pending = SZ_HIGH;
                    o_state.size_high_byte     = 8'd0;
                end
            end else if ((i_item.chunk_len == 8'd0) || !i_state.session_busy
                    || (i_item.handler_id != i_state.owner_id)) begin
                err = 1'b1;
            end else if (hdr_sum > {1'b0, i_state.total_size}) begin
                err = 1'b1;
            end else begin
                o_state.chunk_left = i_item.chunk_len;
            end
        end

        // any violation aborts the session
        if (err) begin
            o_state         = '0;
            o_result        = '0;
            o_result.status = ST_ERR;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cprs_checker.sv =====
// ----------------------------------------------------------------------------
// cprs_checker
// port-level checks of the reassembler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "chunked_payload_reassembler_core_defines.svh"

module cprs_checker
    import cprs_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input t_in_item  i_in_data,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input t_out_item o_out_data
);

    // stalled result holds
    `CPRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // every accepted transaction yields a result next cycle
    `CPRS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

    // no forwarded byte means empty byte fields
    `CPRS_ASSERT_NOW(a_idle_fields, i_clk, i_rst_n, o_out_valid && !o_out_data.byte_valid, (o_out_data.payload_byte == 8'd0) && (o_out_data.byte_offset == '0) && !o_out_data.last)

    // completion and last byte go together
    `CPRS_ASSERT_NOW(a_done_last, i_clk, i_rst_n, o_out_valid, (o_out_data.status == ST_DONE) == (o_out_data.last && o_out_data.byte_valid))

endmodule

bind chunked_payload_reassembler_core cprs_checker u_cprs_checker (.*);

`default_nettype wire

// ===== tb/chunked_payload_reassembler_core_checker.sv =====
// ----------------------------------------------------------------------------
// chunked_payload_reassembler_core_checker
// watches both channels, predicts every result from the accepted input
// transactions and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chunked_payload_reassembler_core_checker
    import cprs_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_in_ready,
    input  t_in_item  i_in_data,
    input  wire       i_out_valid,
    input  wire       i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    // predicted session state
    t_state    session;
    t_out_item expected_results[$];
    int        fail_count = 0;
    int        pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // advance the session by one transaction and return its result
    function automatic t_out_item reassemble_step(input t_in_item item);
        t_out_item   res;
        logic [15:0] size_word;
        res = '0;
        res.status = ST_OK;
        if (item.cmd == CMD_DATA) begin
            if (session.chunk_left == 8'd0) begin
                // byte outside a chunk
                res.status = ST_ERR;
            end else begin
                session.chunk_left = session.chunk_left - 8'd1;
                if (session.size_bytes_pending == SZ_HIGH) begin
                    session.size_high_byte     = item.data_byte;
                    session.size_bytes_pending = SZ_LOW;
                end else if (session.size_bytes_pending == SZ_LOW) begin
                    size_word = {session.size_high_byte, item.data_byte};
                    session.size_bytes_pending = SZ_NONE;
                    session.size_high_byte     = 8'd0;
                    if (size_word == 16'd0 || size_word > 16'(MAX_PAYLOAD)) begin
                        res.status = ST_ERR;
                    end else if ({8'd0, session.chunk_left} > size_word) begin
                        // rest of the first chunk would overrun the size
                        res.status = ST_ERR;
                    end else begin
                        session.total_size = size_word[SIZE_W-1:0];
                    end
                end else begin
                    res.byte_valid   = 1'b1;
                    res.payload_byte = item.data_byte;
                    res.byte_offset  = session.bytes_received;
                    session.bytes_received = session.bytes_received + 10'd1;
                    if (session.bytes_received >= session.total_size) begin
                        res.status = ST_DONE;
                        res.last   = 1'b1;
                        session    = '0;
                    end
                end
            end
        end else begin
            if (session.chunk_left != 8'd0) begin
                // header inside a chunk
                res.status = ST_ERR;
            end else if (item.first_chunk) begin
                if (session.session_busy || item.chunk_len < 8'd2) begin
                    res.status = ST_ERR;
                end else begin
                    session.session_busy       = 1'b1;
                    session.owner_id           = item.handler_id;
                    session.total_size         = '0;
                    session.bytes_received     = '0;
                    session.chunk_left         = item.chunk_len;
                    session.size_bytes_pending = SZ_HIGH;
                    session.size_high_byte     = 8'd0;
                end
            end else if (item.chunk_len == 8'd0 || !session.session_busy
                         || item.handler_id != session.owner_id) begin
                res.status = ST_ERR;
            end else if (int'(session.bytes_received) + int'(item.chunk_len)
                         > int'(session.total_size)) begin
                res.status = ST_ERR;
            end else begin
                session.chunk_left = item.chunk_len;
            end
        end
        if (res.status == ST_ERR) begin
            session = '0;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // compare taken results, then record new expectations
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            session = '0;
            expected_results.delete();
            pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status),
                                32'(i_out_data.status));
                    check_field("byte_valid", 32'(want.byte_valid),
                                32'(i_out_data.byte_valid));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(i_out_data.payload_byte));
                    check_field("byte_offset", 32'(want.byte_offset),
                                32'(i_out_data.byte_offset));
                    check_field("last", 32'(want.last), 32'(i_out_data.last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(reassemble_step(i_in_data));
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/chunked_payload_reassembler_core_test.sv =====
// ----------------------------------------------------------------------------
// chunked_payload_reassembler_core_test
// drives directed error cases, then random chunked payloads with injected
// faults under three idling patterns; the checker judges every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module chunked_payload_reassembler_core_test;
    import cprs_pkg::*;

    localparam int ITEMS_PER_PHASE = 533;
    localparam int MAX_GAP         = 20;
    localparam int IN_W            = $bits(t_in_item);

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;

    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        items_sent = 0;

    chunked_payload_reassembler_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    chunked_payload_reassembler_core_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // present one transaction and hold it until accepted
    task automatic send_item(input t_in_item item);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // header with a random ignored data byte
    function automatic t_in_item header_item(input logic first, input logic [7:0] len,
                                             input logic [7:0] id);
        t_in_item item;
        item.cmd         = CMD_HEADER;
        item.first_chunk = first;
        item.chunk_len   = len;
        item.handler_id  = id;
        item.data_byte   = 8'($urandom_range(255));
        return item;
    endfunction

    // data byte with random ignored header fields
    function automatic t_in_item data_item(input logic [7:0] value);
        t_in_item item;
        item.cmd         = CMD_DATA;
        item.first_chunk = 1'($urandom_range(1));
        item.chunk_len   = 8'($urandom_range(255));
        item.handler_id  = 8'($urandom_range(255));
        item.data_byte   = value;
        return item;
    endfunction

    // a transaction that breaks the session in progress
    function automatic t_in_item broken_item(input logic [7:0] owner);
        logic [IN_W-1:0] raw;
        case ($urandom_range(5))
            0: begin
                raw = IN_W'($urandom);
                return t_in_item'(raw);
            end
            1: return header_item(1'b0, 8'($urandom_range(1, 255)),
                                  owner ^ 8'($urandom_range(1, 255)));
            2: return header_item(1'b0, 8'd0, owner);
            3: return header_item(1'b1, 8'($urandom_range(1) ? $urandom_range(0, 1)
                                  : $urandom_range(255)), 8'($urandom_range(255)));
            4: return data_item(8'($urandom_range(255)));
            default: return header_item(1'b0, 8'd255, owner);
        endcase
    endfunction

    // send one item of a session, sometimes preceded by a fault
    task automatic send_in_session(input t_in_item item, input logic noisy,
                                   input logic [7:0] owner);
        if (noisy && $urandom_range(99) < 3) begin
            send_item(broken_item(owner));
        end
        send_item(item);
    endtask

    // a complete payload of the given size in random chunks
    task automatic send_payload(input int size, input logic noisy);
        logic [7:0] owner;
        int         remaining;
        int         len;
        owner     = 8'($urandom_range(255));
        len       = $urandom_range(0, (size < 253) ? size : 253);
        remaining = size - len;
        send_in_session(header_item(1'b1, 8'(len + 2), owner), noisy, owner);
        send_in_session(data_item(8'(size >> 8)), noisy, owner);
        send_in_session(data_item(8'(size)), noisy, owner);
        repeat (len) send_in_session(data_item(8'($urandom_range(255))), noisy, owner);
        while (remaining > 0) begin
            len = $urandom_range(1, (remaining < 255) ? remaining : 255);
            remaining -= len;
            send_in_session(header_item(1'b0, 8'(len), owner), noisy, owner);
            repeat (len) send_in_session(data_item(8'($urandom_range(255))), noisy, owner);
        end
    endtask

    // hold the sender off until every expected result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // directed cases, then random payloads in three idling phases
    initial begin
        int pick;
        int size;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 32;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 32;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // byte outside a chunk, following chunk without a session
                send_item(data_item(8'h00));
                send_item(header_item(1'b0, 8'd4, 8'h00));
                // short first chunk
                send_item(header_item(1'b1, 8'd1, 8'h10));
                // declared size zero, then one above the maximum
                send_item(header_item(1'b1, 8'd2, 8'h10));
                send_item(data_item(8'h00));
                send_item(data_item(8'h00));
                send_item(header_item(1'b1, 8'd2, 8'h10));
                send_item(data_item(8'h03));
                send_item(data_item(8'hfd));
                // first chunk longer than the declared size
                send_item(header_item(1'b1, 8'd4, 8'h10));
                send_item(data_item(8'h00));
                send_item(data_item(8'h01));
                // one-byte payload completed inside the first chunk
                send_item(header_item(1'b1, 8'd3, 8'hff));
                send_item(data_item(8'h00));
                send_item(data_item(8'h01));
                send_item(data_item(8'hff));
                // maximum size accepted, then a first chunk while busy
                send_item(header_item(1'b1, 8'd3, 8'h5a));
                send_item(data_item(8'h03));
                send_item(data_item(8'hfc));
                send_item(data_item(8'h80));
                send_item(header_item(1'b1, 8'd2, 8'h5a));
                // header inside a chunk
                send_item(header_item(1'b1, 8'd4, 8'h22));
                send_item(data_item(8'h00));
                send_item(header_item(1'b0, 8'd1, 8'h22));
            end

            while (items_sent < (phase + 1) * ITEMS_PER_PHASE + 24) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    send_item(broken_item(8'($urandom_range(255))));
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 3) begin
                        size = $urandom_range(256, MAX_PAYLOAD);
                    end else if (pick < 10) begin
                        size = $urandom_range(41, 255);
                    end else begin
                        size = $urandom_range(1, 40);
                    end
                    send_payload(size, $urandom_range(99) < 20);
                    if ($urandom_range(99) < 5) begin
                        wait_drained();
                    end
                end
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("chunked_payload_reassembler_core verification clean");
        end else begin
            $display("chunked_payload_reassembler_core verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("chunked_payload_reassembler_core verification failed");
        $finish;
    end

endmodule
